// ===== src/rotated_brief_descriptor_macros.svh =====
// Assertion macros shared by the checker.
`ifndef ROTATED_BRIEF_DESCRIPTOR_MACROS_SVH
`define ROTATED_BRIEF_DESCRIPTOR_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define RBD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define RBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== src/rbd_pkg.sv =====
package rbd_pkg;
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_PAIR  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;
  localparam int CORDIC_STEPS = 16;
  localparam logic signed [15:0] Q14_ONE = 16'sd16384;
  localparam logic signed [15:0] CORDIC_START = 16'sd9949;
  localparam int WORD_BITS = 32;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MOM_RD, ST_MOM_ACC, ST_VEC, ST_ROT, ST_FIN,
    ST_PAIR_P, ST_PAIR_Q, ST_PAIR_RDP, ST_PAIR_RDQ, ST_PAIR_CMP, ST_OUT
  } state_t;
endpackage

// ===== src/rbd_ram.sv =====
module rbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/rotated_brief_descriptor.sv =====
// Channel | Direction | tdata (low bit up)                                 | tuser / tlast
// in_     | slave     | pixel_row, pixel_col, pixel_value, p_first,       | command /
//         |           | p_second, q_first, q_second (40 bits)             | last_pair
// out_    | master    | desc_word, word_number (35 bits in 40)            | - / final_word
// Load: accept, then patch write. Command 3: accepted and ignored. Start: each window
// pixel is read through the single patch RAM read port and accumulated, then one set-up
// step, then 16 vectoring and 16 rotation steps on one shared add/shift unit; these are
// skipped when both moments are zero. Pair: accept, two rotations on one multiplier set,
// two registered RAM reads and a compare; a pair that closes a word holds the sequencer
// in ST_OUT until the transfer completes. Reset (rst_n low, synchronous) clears control
// state and restores cos=1, sin=0; in_tready is high only in ST_IDLE.
module rotated_brief_descriptor #(
  parameter int PATCH_SIZE    = 64,
  parameter int MOMENT_RADIUS = 4,
  parameter int DESC_BITS     = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // pixel_row, pixel_col, pixel_value, p_first, p_second,
                                  // q_first, q_second
  input  logic [1:0]  in_tuser,   // command
  input  logic        in_tlast,   // last_pair
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // desc_word, word_number
  output logic        out_tlast   // final_word
);
  localparam int AW   = $clog2(PATCH_SIZE);
  localparam int MW   = $clog2(PATCH_SIZE * PATCH_SIZE);
  localparam int WIN  = 2 * MOMENT_RADIUS + 1;
  localparam int WW   = $clog2(WIN + 1);
  localparam int PW   = $clog2(DESC_BITS);
  localparam int CENTRE = PATCH_SIZE / 2;
  localparam int XW   = 48; // moments under 2^16 scaled by 2^24, CORDIC gain and sign

  rbd_pkg::state_t state_r, state_nxt;

  // Hold the accepted item.
  logic [1:0]        cmd_r;
  logic [39:0]       dat_r;
  logic              last_r;
  // Orientation.
  logic signed [15:0] cos_r, sin_r;
  logic [WW-1:0]      wr_r, wc_r;          // window row/col counters
  logic signed [23:0] mrow_r, mcol_r;
  logic signed [XW-1:0] x_r, y_r;
  logic [rbd_pkg::CORDIC_STEPS-1:0] dir_r;
  logic [3:0]         it_r;
  logic               flip_r;
  logic               init_done_r;
  // Pair.
  logic [PW:0]        pidx_r;
  logic [31:0]        bits_r;
  logic [MW-1:0]      paddr_r, qaddr_r;
  logic [7:0]         pv_r;
  // Output.
  logic [31:0]        odesc_r;
  logic [2:0]         onum_r;
  logic               ofin_r;

  // Patch memory.
  logic          ram_we;
  logic [MW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_rdata;

  rbd_ram #(.WIDTH(8), .DEPTH(PATCH_SIZE * PATCH_SIZE)) u_patch (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(dat_r[19:12]),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // Clamp a centred signed offset to the patch.
  function automatic logic [AW-1:0] clampc(input logic signed [7:0] off);
    logic signed [9:0] v;
    v = 10'(off) + 10'(CENTRE);
    if (v < 0) return '0;
    if (v > 10'(PATCH_SIZE - 1)) return AW'(PATCH_SIZE - 1);
    return v[AW-1:0];
  endfunction

  // Rotation of one offset pair: one shared set of multipliers.
  logic signed [4:0]  fa, fb;
  logic signed [21:0] r_full, c_full;
  logic signed [7:0]  r_off, c_off;
  logic [MW-1:0]      rot_addr;
  always_comb begin
    if (state_r == rbd_pkg::ST_PAIR_P) begin
      fa = dat_r[24:20];
      fb = dat_r[29:25];
    end else begin
      fa = dat_r[34:30];
      fb = dat_r[39:35];
    end
    r_full = 22'(fa) * 22'(cos_r) - 22'(fb) * 22'(sin_r);
    c_full = 22'(fa) * 22'(sin_r) + 22'(fb) * 22'(cos_r);
    // Divide by 2^14 truncating toward zero.
    r_off = r_full[21] ? -8'((-r_full) >>> 14) : 8'(r_full >>> 14);
    c_off = c_full[21] ? -8'((-c_full) >>> 14) : 8'(c_full >>> 14);
    rot_addr = MW'(clampc(r_off)) * MW'(PATCH_SIZE) + MW'(clampc(c_off));
  end

  // Window address and offsets.
  logic signed [7:0] wl, wu;
  logic [MW-1:0]     win_addr;
  always_comb begin
    wl = 8'(wr_r) - 8'(MOMENT_RADIUS);
    wu = 8'(wc_r) - 8'(MOMENT_RADIUS);
    win_addr = MW'(clampc(wl)) * MW'(PATCH_SIZE) + MW'(clampc(wu));
  end

  // Shared CORDIC add/shift unit.
  logic signed [XW-1:0] sa, sb, sha, shb;
  logic                 dsel;
  logic signed [XW-1:0] ua, ub;
  always_comb begin
    if (state_r == rbd_pkg::ST_VEC) begin
      sa = x_r; sb = y_r; dsel = ~y_r[XW-1];
    end else begin
      sa = x_r; sb = y_r; dsel = dir_r[it_r];
    end
    sha = sa >>> it_r;
    shb = sb >>> it_r;
    if (state_r == rbd_pkg::ST_VEC) begin
      ua = dsel ? sa + shb : sa - shb;
      ub = dsel ? sb - sha : sb + sha;
    end else begin
      ua = dsel ? sa - shb : sa + shb;
      ub = dsel ? sb + sha : sb - sha;
    end
  end

  function automatic logic signed [15:0] sat(input logic signed [XW-1:0] v);
    if (v > XW'(rbd_pkg::Q14_ONE)) return rbd_pkg::Q14_ONE;
    if (v < -XW'(rbd_pkg::Q14_ONE)) return -rbd_pkg::Q14_ONE;
    return v[15:0];
  endfunction

  logic in_acc, out_acc;
  logic [4:0] bitpos;
  logic       pair_last, emit;
  assign in_acc   = in_tvalid && in_tready;
  assign out_acc  = out_tvalid && out_tready;
  assign bitpos   = pidx_r[4:0];
  assign pair_last = last_r || (pidx_r >= (PW+1)'(DESC_BITS - 1));
  assign emit     = pair_last || (bitpos == 5'd31);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rbd_pkg::ST_IDLE: if (in_acc) begin
        unique case (in_tuser)
          rbd_pkg::CMD_LOAD:  state_nxt = rbd_pkg::ST_FIN;
          rbd_pkg::CMD_START: state_nxt = rbd_pkg::ST_MOM_RD;
          rbd_pkg::CMD_PAIR:  state_nxt = rbd_pkg::ST_PAIR_P;
          rbd_pkg::CMD_NONE:  state_nxt = rbd_pkg::ST_IDLE;
        endcase
      end
      rbd_pkg::ST_MOM_RD:  state_nxt = rbd_pkg::ST_MOM_ACC;
      rbd_pkg::ST_MOM_ACC: begin
        if (wr_r == WW'(WIN - 1) && wc_r == WW'(WIN - 1)) state_nxt = rbd_pkg::ST_VEC;
        else state_nxt = rbd_pkg::ST_MOM_RD;
      end
      rbd_pkg::ST_VEC: begin
        if (mrow_r == 0 && mcol_r == 0) state_nxt = rbd_pkg::ST_IDLE;
        else if (it_r == 4'd15) state_nxt = rbd_pkg::ST_ROT;
      end
      rbd_pkg::ST_ROT:     if (it_r == 4'd15) state_nxt = rbd_pkg::ST_IDLE;
      rbd_pkg::ST_FIN:     state_nxt = rbd_pkg::ST_IDLE;
      rbd_pkg::ST_PAIR_P:  state_nxt = rbd_pkg::ST_PAIR_Q;
      rbd_pkg::ST_PAIR_Q:  state_nxt = rbd_pkg::ST_PAIR_RDP;
      rbd_pkg::ST_PAIR_RDP: state_nxt = rbd_pkg::ST_PAIR_RDQ;
      rbd_pkg::ST_PAIR_RDQ: state_nxt = rbd_pkg::ST_PAIR_CMP;
      rbd_pkg::ST_PAIR_CMP: state_nxt = emit ? rbd_pkg::ST_OUT : rbd_pkg::ST_IDLE;
      rbd_pkg::ST_OUT:     if (out_acc) state_nxt = rbd_pkg::ST_IDLE;
      default:             state_nxt = rbd_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_tready = (state_r == rbd_pkg::ST_IDLE);
    out_tvalid = (state_r == rbd_pkg::ST_OUT);
    // Drop a load whose row or column lies outside the patch.
    ram_we    = (state_r == rbd_pkg::ST_FIN) && (cmd_r == rbd_pkg::CMD_LOAD) &&
                (int'(dat_r[5:0]) < PATCH_SIZE) && (int'(dat_r[11:6]) < PATCH_SIZE);
    ram_waddr = MW'(dat_r[5:0]) * MW'(PATCH_SIZE) + MW'(dat_r[11:6]);
    unique case (state_r)
      rbd_pkg::ST_PAIR_RDP: ram_raddr = paddr_r;
      rbd_pkg::ST_PAIR_RDQ: ram_raddr = qaddr_r;
      default:              ram_raddr = win_addr;
    endcase
  end
  assign out_tdata = {5'd0, onum_r, odesc_r};
  assign out_tlast = ofin_r;

  logic signed [23:0] pxs;
  assign pxs = 24'(ram_rdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rbd_pkg::ST_IDLE;
      cos_r   <= rbd_pkg::Q14_ONE;
      sin_r   <= '0;
      pidx_r  <= '0;
      bits_r  <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        rbd_pkg::ST_IDLE: if (in_acc) begin
          cmd_r  <= in_tuser;
          dat_r  <= in_tdata;
          last_r <= in_tlast;
          wr_r   <= '0;
          wc_r   <= '0;
          mrow_r <= '0;
          mcol_r <= '0;
          if (in_tuser == rbd_pkg::CMD_START) begin
            pidx_r <= '0;
            bits_r <= '0;
          end
        end
        rbd_pkg::ST_MOM_ACC: begin
          mrow_r <= mrow_r + 24'(wl) * pxs;
          mcol_r <= mcol_r + 24'(wu) * pxs;
          if (wc_r == WW'(WIN - 1)) begin
            wc_r <= '0;
            wr_r <= wr_r + 1'b1;
          end else begin
            wc_r <= wc_r + 1'b1;
          end
          // Reset the step counter for the vectoring stage.
          it_r <= '0;
        end
        rbd_pkg::ST_VEC: begin
          if (mrow_r == 0 && mcol_r == 0) begin
            cos_r <= rbd_pkg::Q14_ONE;
            sin_r <= '0;
          end else if (it_r == 4'd0 && !init_done_r) begin
            flip_r <= mrow_r[23];
            x_r    <= mrow_r[23] ? -(XW'(mrow_r) <<< 24) : (XW'(mrow_r) <<< 24);
            y_r    <= mrow_r[23] ? -(XW'(mcol_r) <<< 24) : (XW'(mcol_r) <<< 24);
          end else begin
            dir_r[it_r] <= dsel;
            if (it_r == 4'd15) begin
              x_r <= XW'(rbd_pkg::CORDIC_START);
              y_r <= '0;
            end else begin
              x_r <= ua;
              y_r <= ub;
            end
            it_r <= it_r + 1'b1;
          end
        end
        rbd_pkg::ST_ROT: begin
          x_r  <= ua;
          y_r  <= ub;
          it_r <= it_r + 1'b1;
          if (it_r == 4'd15) begin
            cos_r <= flip_r ? sat(-ua) : sat(ua);
            sin_r <= flip_r ? sat(-ub) : sat(ub);
          end
        end
        rbd_pkg::ST_PAIR_P: paddr_r <= rot_addr;
        rbd_pkg::ST_PAIR_Q: qaddr_r <= rot_addr;
        rbd_pkg::ST_PAIR_RDQ: pv_r <= ram_rdata;
        rbd_pkg::ST_PAIR_CMP: begin
          if (emit) begin
            odesc_r <= bits_r | ((pv_r > ram_rdata) ? (32'd1 << bitpos) : 32'd0);
            onum_r  <= 3'(pidx_r >> 5);
            ofin_r  <= pair_last;
            bits_r  <= '0;
            pidx_r  <= pair_last ? '0 : pidx_r + 1'b1;
          end else begin
            if (pv_r > ram_rdata) bits_r <= bits_r | (32'd1 << bitpos);
            pidx_r <= pidx_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Vectoring uses one set-up step at step zero before the first vectoring step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_done_r <= 1'b0;
    end else if (state_r == rbd_pkg::ST_VEC) begin
      init_done_r <= 1'b1;
    end else begin
      init_done_r <= 1'b0;
    end
  end
endmodule

// ===== src/rbd_checker.sv =====
`include "rotated_brief_descriptor_macros.svh"
module rbd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);
  // Busy with a result: no new input taken.
  `RBD_ASSERT_IMP(a_no_in_while_out, out_tvalid, !in_tready, "input ready while word pending")
  // A stalled word keeps its payload.
  `RBD_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "word changed under stall")
  // Padding bits stay zero.
  `RBD_ASSERT_IMP(a_pad, out_tvalid, out_tdata[39:35] == 5'd0, "padding nonzero")
  // A completed command transfer drops ready for the work that follows.
  `RBD_ASSERT_NEXT(a_busy, in_tvalid && in_tready && in_tuser != rbd_pkg::CMD_NONE, !in_tready, "ready right after transfer")
endmodule

bind rotated_brief_descriptor rbd_checker u_rbd_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .in_tuser, .out_tvalid, .out_tready, .out_tdata,
  .out_tlast
);

// ===== sim/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PATCH = 64;
  localparam int RAD = 4;
  localparam int NBITS = 256;
  localparam int FILL = 10; // half-width of the loaded square around the keypoint

  logic        clk, rst_n;
  logic        in_tvalid, in_tready, in_tlast;
  logic [39:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid, out_tready, out_tlast;
  logic [39:0] out_tdata;

  rotated_brief_descriptor u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  // One descriptor word as it leaves the block.
  typedef struct packed {
    logic [31:0] bits;
    logic [2:0]  num;
    logic        fin;
  } desc_word_t;

  // Shadow state of the descriptor engine.
  logic [7:0]  patch_mem [PATCH*PATCH];
  longint      cos_q14, sin_q14;
  int unsigned pair_cnt;
  logic [31:0] bits_acc;

  desc_word_t words_due[$];
  int mismatches, words_seen, items_sent;
  bit timed_out;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hold a generous limit: orientation runs are long.
  initial begin
    #100ms;
    $display("Timeout waiting for descriptor traffic");
    $display("*** FAILED ***");
    $finish;
  end

  function automatic longint fshift(longint v, int s);
    return v >= 0 ? (v >>> s) : ~((~v) >>> s);
  endfunction

  function automatic int clampc(longint v);
    if (v < 0) return 0;
    if (v > PATCH - 1) return PATCH - 1;
    return int'(v);
  endfunction

  function automatic logic [7:0] pix_at(longint r, longint c);
    return patch_mem[clampc(r) * PATCH + clampc(c)];
  endfunction

  function automatic longint sat14(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  function automatic longint div14(longint v);
    return v >= 0 ? (v >>> 14) : -((-v) >>> 14);
  endfunction

  // Derive the keypoint orientation from the window moments.
  task automatic steer_angle();
    longint mr, mc, x, y, c, s, nx, ny;
    bit dir [rbd_pkg::CORDIC_STEPS];
    bit flip;
    mr = 0; mc = 0; flip = 0;
    for (int l = -RAD; l <= RAD; l++)
      for (int u = -RAD; u <= RAD; u++) begin
        mr += l * longint'(pix_at(PATCH/2 + l, PATCH/2 + u));
        mc += u * longint'(pix_at(PATCH/2 + l, PATCH/2 + u));
      end
    if (mr == 0 && mc == 0) begin
      cos_q14 = 16384; sin_q14 = 0;
      return;
    end
    x = mr <<< 24; y = mc <<< 24;
    if (x < 0) begin
      x = -x; y = -y; flip = 1;
    end
    for (int i = 0; i < rbd_pkg::CORDIC_STEPS; i++) begin
      if (y >= 0) begin
        nx = x + fshift(y, i); ny = y - fshift(x, i); dir[i] = 1;
      end else begin
        nx = x - fshift(y, i); ny = y + fshift(x, i); dir[i] = 0;
      end
      x = nx; y = ny;
    end
    c = 9949; s = 0;
    for (int i = 0; i < rbd_pkg::CORDIC_STEPS; i++) begin
      if (dir[i]) begin
        nx = c - fshift(s, i); ny = s + fshift(c, i);
      end else begin
        nx = c + fshift(s, i); ny = s - fshift(c, i);
      end
      c = nx; s = ny;
    end
    if (flip) begin
      c = -c; s = -s;
    end
    cos_q14 = sat14(c);
    sin_q14 = sat14(s);
  endtask

  function automatic logic [7:0] steered_pix(logic signed [4:0] a, logic signed [4:0] b);
    longint r, c;
    r = div14(a * cos_q14 - b * sin_q14);
    c = div14(a * sin_q14 + b * cos_q14);
    return pix_at(PATCH/2 + r, PATCH/2 + c);
  endfunction

  // Advance the shadow engine by one accepted transfer; queue any word it yields.
  task automatic predict_descriptor(logic [1:0] cmd, logic [39:0] d, logic lastp);
    logic [7:0] pv, qv;
    bit fin;
    desc_word_t w;
    case (cmd)
      rbd_pkg::CMD_LOAD: begin
        patch_mem[d[5:0] * PATCH + d[11:6]] = d[19:12];
      end
      rbd_pkg::CMD_START: begin
        steer_angle();
        pair_cnt = 0; bits_acc = '0;
      end
      rbd_pkg::CMD_PAIR: begin
        pv = steered_pix(d[24:20], d[29:25]);
        qv = steered_pix(d[34:30], d[39:35]);
        fin = lastp || pair_cnt >= NBITS - 1;
        if (pv > qv) bits_acc[pair_cnt % 32] = 1'b1;
        if (fin || pair_cnt % 32 == 31) begin
          w.bits = bits_acc; w.num = pair_cnt[7:5]; w.fin = fin;
          words_due.insert(words_due.size(), w);
          bits_acc = '0;
          pair_cnt = fin ? 0 : (pair_cnt + 1) % 512;
        end else begin
          pair_cnt = (pair_cnt + 1) % 512;
        end
      end
      default: ;
    endcase
  endtask

  // Check each word transfer against the oldest prediction.
  always @(posedge clk) begin
    desc_word_t exp_w, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.bits = out_tdata[31:0]; got.num = out_tdata[34:32]; got.fin = out_tlast;
      words_seen++;
      if (words_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected word %h", got);
      end else begin
        exp_w = words_due.pop_front();
        if (exp_w !== got || out_tdata[39:35] !== 5'b0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Word mismatch: exp bits=%h num=%0d fin=%0b, got bits=%h num=%0d fin=%0b",
                     exp_w.bits, exp_w.num, exp_w.fin, got.bits, got.num, got.fin);
        end
      end
    end
  end

  // Receiver back-pressure: mostly short stalls, occasionally long, runs with none.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 9) < 6) out_tready = 1'b1;
      else begin
        out_tready = 1'b0;
        repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 40) : $urandom_range(0, 2))
          @(negedge clk);
      end
    end
  end

  // Present one transfer, wait for its handshake, then update the prediction.
  task automatic send_item(logic [1:0] cmd, logic [39:0] d, logic lastp);
    if ($urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(0, 19) == 0 ? $urandom_range(5, 30) : $urandom_range(1, 3))
        @(negedge clk);
    end
    in_tvalid = 1'b1; in_tuser = cmd; in_tdata = d; in_tlast = lastp;
    do @(posedge clk); while (!in_tready);
    predict_descriptor(cmd, d, lastp);
    items_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  function automatic logic [39:0] load_data(int r, int c, int v);
    return {20'b0, 8'(v), 6'(c), 6'(r)};
  endfunction

  function automatic logic [39:0] pair_data(int pa, int pb, int qa, int qb);
    return {5'(qb), 5'(qa), 5'(pb), 5'(pa), 20'b0};
  endfunction

  // Random offsets stay small enough that every rotated point lands in the loaded square.
  function automatic int roff();
    return $urandom_range(0, 14) - 7;
  endfunction

  // Random pair; pixel bits left random too.
  function automatic logic [39:0] rnd_pair();
    logic [39:0] d;
    d = pair_data(roff(), roff(), roff(), roff());
    d[19:0] = 20'($urandom());
    return d;
  endfunction

  typedef struct {
    logic [1:0]  cmd;
    logic [39:0] d;
    logic        lastp;
    bit          has_exp;
    desc_word_t  exp_w;
  } stim_row_t;

  stim_row_t rows[$];

  task automatic add_row(logic [1:0] cmd, logic [39:0] d, logic lastp, bit has_exp,
                         logic [31:0] eb, logic [2:0] en, logic ef);
    stim_row_t r;
    r.cmd = cmd; r.d = d; r.lastp = lastp; r.has_exp = has_exp;
    r.exp_w.bits = eb; r.exp_w.num = en; r.exp_w.fin = ef;
    rows.insert(rows.size(), r);
  endtask

  initial begin
    logic [39:0] d;
    int npairs, nstart;
    in_tvalid = 1'b0; in_tuser = rbd_pkg::CMD_LOAD; in_tdata = '0; in_tlast = 1'b0;
    rst_n = 1'b0;
    mismatches = 0; words_seen = 0; items_sent = 0; timed_out = 0;
    cos_q14 = 16384; sin_q14 = 0; pair_cnt = 0; bits_acc = '0;
    for (int i = 0; i < PATCH*PATCH; i++) patch_mem[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Fill the square around the keypoint that windows and random pairs can reach.
    for (int r = PATCH/2 - FILL; r <= PATCH/2 + FILL; r++)
      for (int c = PATCH/2 - FILL; c <= PATCH/2 + FILL; c++)
        send_item(rbd_pkg::CMD_LOAD, load_data(r, c, $urandom_range(0, 255)), 1'b0);

    // Directed table: reset angle, extremes, ignored command, start/clear, last pair.
    add_row(rbd_pkg::CMD_LOAD, load_data(PATCH/2 - 15, PATCH/2 - 15, 0), 1'b0, 0, 0, 0, 0);
    add_row(rbd_pkg::CMD_LOAD, load_data(PATCH/2 + 15, PATCH/2 + 15, 255), 1'b0, 0, 0, 0, 0);
    add_row(rbd_pkg::CMD_LOAD, load_data(PATCH/2 - 15, PATCH/2 + 15, 100), 1'b0, 0, 0, 0, 0);
    add_row(rbd_pkg::CMD_LOAD, load_data(PATCH/2 + 15, PATCH/2 - 15, 200), 1'b0, 0, 0, 0, 0);
    add_row(rbd_pkg::CMD_PAIR, pair_data(-15, -15, 15, 15), 1'b1, 1, 32'h0, 3'd0, 1'b1);
    add_row(rbd_pkg::CMD_PAIR, pair_data(15, 15, -15, -15), 1'b1, 1, 32'h1, 3'd0, 1'b1);
    add_row(rbd_pkg::CMD_NONE, 40'hFF_FFFF_FFFF, 1'b1, 0, 0, 0, 0);
    add_row(rbd_pkg::CMD_PAIR, pair_data(0, 0, 0, 0), 1'b1, 1, 32'h0, 3'd0, 1'b1);
    add_row(rbd_pkg::CMD_PAIR, pair_data(15, -15, -15, 15), 1'b0, 0, 0, 0, 0);
    add_row(rbd_pkg::CMD_PAIR, pair_data(-15, 15, 15, -15), 1'b1, 1, 32'h1, 3'd0, 1'b1);
    add_row(rbd_pkg::CMD_START, '0, 1'b0, 0, 0, 0, 0);
    add_row(rbd_pkg::CMD_PAIR, pair_data(7, -7, -7, 7), 1'b0, 0, 0, 0, 0);
    add_row(rbd_pkg::CMD_PAIR, pair_data(-7, 7, 7, -7), 1'b0, 0, 0, 0, 0);
    add_row(rbd_pkg::CMD_START, 40'hFF_FFFF_FFFF, 1'b1, 0, 0, 0, 0);
    add_row(rbd_pkg::CMD_LOAD, load_data(PATCH/2, PATCH/2 + 4, 255), 1'b0, 0, 0, 0, 0);
    add_row(rbd_pkg::CMD_LOAD, load_data(PATCH/2 - 4, PATCH/2, 0), 1'b0, 0, 0, 0, 0);
    add_row(rbd_pkg::CMD_START, '0, 1'b0, 0, 0, 0, 0);
    add_row(rbd_pkg::CMD_PAIR, pair_data(7, 0, 0, 7), 1'b1, 0, 0, 0, 0);
    foreach (rows[i]) begin
      if (rows[i].has_exp) begin
        // Typed-in expectation: compare the predictor against it after the transfer.
        d = rows[i].d;
        send_item(rows[i].cmd, d, rows[i].lastp);
        if (words_due.size() == 0 || words_due[$] !== rows[i].exp_w) begin
          mismatches++;
          if (mismatches <= 10) $display("Directed row %0d: prediction disagrees with table", i);
        end
      end else begin
        send_item(rows[i].cmd, rows[i].d, rows[i].lastp);
      end
    end
    // Full 256-pair descriptor with no last marker, then wrap into a new one.
    for (int i = 0; i < 260; i++) send_item(rbd_pkg::CMD_PAIR, rnd_pair(), 1'b0);
    send_item(rbd_pkg::CMD_PAIR, rnd_pair(), 1'b1);

    // Random part: keypoints made of a few loads near the centre, a start and pairs.
    nstart = 0;
    while (items_sent < 1950) begin
      repeat ($urandom_range(0, 6)) begin
        d = load_data($urandom_range(PATCH/2 - RAD - 1, PATCH/2 + RAD + 1),
                      $urandom_range(PATCH/2 - RAD - 1, PATCH/2 + RAD + 1),
                      $urandom_range(0, 255));
        d[39:20] = 20'($urandom());
        send_item(rbd_pkg::CMD_LOAD, d, 1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 9) != 0) begin
        send_item(rbd_pkg::CMD_START, {$urandom(), 8'($urandom())}, 1'($urandom_range(0, 1)));
        nstart++;
      end
      if ($urandom_range(0, 9) == 0)
        send_item(rbd_pkg::CMD_NONE, {$urandom(), 8'($urandom())}, 1'b1);
      npairs = $urandom_range(0, 3) == 0 ? $urandom_range(1, 300) : $urandom_range(1, 70);
      for (int i = 0; i < npairs; i++)
        send_item(rbd_pkg::CMD_PAIR, rnd_pair(), i == npairs - 1 && $urandom_range(0, 3) != 0);
    end

    // Drain: wait for outstanding words, then let the block settle.
    fork
      begin
        wait (words_due.size() == 0);
        repeat (50) @(posedge clk);
      end
      begin
        repeat (200000) @(posedge clk);
        timed_out = 1;
      end
    join_any
    disable fork;
    $display("Sent %0d transfers (%0d random keypoint starts), checked %0d descriptor words",
             items_sent, nstart, words_seen);
    if (timed_out) begin
      $display("Drain timed out with %0d words outstanding", words_due.size());
      $display("*** FAILED ***");
    end else if (mismatches == 0 && words_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
